/* hw/rtl/mbt_pkg.sv */
// Shared types, constants and sigmoid table for the perceptron trainer.
// No dependencies.
package mbt_pkg;

  localparam int NODES      = 3;
  localparam int LAYER_W    = (NODES + 1) * NODES;
  localparam int NUM_W      = 2 * LAYER_W;
  localparam int KW         = $clog2(NODES + 1);
  localparam int LW         = $clog2(NODES);
  localparam int FEAT_BITS  = 16;
  localparam int ACT_BITS   = 13;
  localparam int ONE_Q12    = 4096;
  localparam int GRAD_BITS  = 40;
  localparam int DIV_CW     = $clog2(GRAD_BITS);
  localparam int SIG_DEPTH  = 256;
  localparam int SIG_AW     = $clog2(SIG_DEPTH);

  typedef enum logic [1:0] {
    CMD_WRITE    = 2'd0,
    CMD_TRAIN    = 2'd1,
    CMD_APPLY    = 2'd2,
    CMD_CLASSIFY = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_WRITE, ST_FWD, ST_SIG, ST_MERGE, ST_BKMUL, ST_BKSUM, ST_BKD1,
    ST_GMUL, ST_GADD, ST_GCLR, ST_DLOAD, ST_DSTEP, ST_DEND, ST_FINISH
  } state_t;

  typedef enum logic [3:0] {
    L_NOP, L_WRITE, L_MAC, L_SIG, L_BKMUL, L_D1, L_GMUL, L_GADD, L_GCLR,
    L_DLOAD, L_DSTEP, L_DEND
  } lane_op_t;

  typedef struct packed {
    lane_op_t                     op;
    logic                         layer;
    logic [KW-1:0]                k;
    logic [LW-1:0]                lane;
    logic signed [FEAT_BITS-1:0]  act0;
    logic signed [FEAT_BITS-1:0]  act1;
    logic signed [FEAT_BITS-1:0]  wdata;
  } ctl_t;

  typedef struct packed {
    cmd_t                               cmd;
    logic [4:0]                         idx;
    logic [FEAT_BITS-1:0]               wval;
    logic [NODES-1:0][FEAT_BITS-1:0]    feat;
    logic [NODES-1:0][FEAT_BITS-1:0]    targ;
  } item_t;

  typedef logic [SIG_DEPTH-1:0][ACT_BITS-1:0] sig_rom_t;

  // restoring divide, table build only
  function automatic longint unsigned udiv64(input longint unsigned a,
                                              input longint unsigned b);
    longint unsigned q, r;
    int i;
    q = 0;
    r = 0;
    for (i = 63; i >= 0; i--) begin
      r = (r << 1) | ((a >> i) & 64'd1);
      if (r >= b) begin
        r = r - b;
        q = q | (64'd1 << i);
      end
    end
    return q;
  endfunction

  // signed divide, truncates toward zero
  function automatic longint sdiv_trunc(input longint a, input longint unsigned b);
    longint unsigned m;
    longint q;
    m = (a < 0) ? longint'(-a) : longint'(a);
    q = longint'(udiv64(m, b));
    return (a < 0) ? -q : q;
  endfunction

  // sigmoid at bin center, Q30 series for exp of the fraction
  function automatic logic [ACT_BITS-1:0] sig_entry(input int u);
    longint unsigned mag, t, n, e, den, s, i;
    longint f, term, sum, q30, prod, quo;
    longint unsigned einv;
    int k;
    q30  = 64'sd1 <<< 30;
    einv = 64'd395007542;
    mag  = (u < 0) ? longint'(-u) : longint'(u);
    t    = (mag << 33) >> SIG_AW;
    n    = t >> 30;
    f    = longint'(t & 64'h3FFF_FFFF);
    term = q30;
    sum  = q30;
    for (k = 1; k <= 14; k++) begin
      prod = term * f;
      quo  = (prod < 0) ? -((-prod) >>> 30) : (prod >>> 30);
      term = sdiv_trunc(-quo, 64'(k));
      sum  = sum + term;
    end
    e = (sum < 0) ? 64'd0 : longint'(sum);
    for (i = 0; i < n; i++) e = (e * einv) >> 30;
    den = longint'(q30) + e;
    s   = udiv64((64'd1 << 42) + (den >> 1), den);
    return (u < 0) ? ACT_BITS'(longint'(ONE_Q12) - longint'(s)) : ACT_BITS'(s);
  endfunction

  function automatic sig_rom_t build_sig_rom();
    sig_rom_t r;
    int i;
    for (i = 0; i < SIG_DEPTH; i++) r[i] = sig_entry(2 * i + 1 - SIG_DEPTH);
    return r;
  endfunction

  localparam sig_rom_t SIG_ROM = build_sig_rom();

endpackage

/* hw/rtl/mlp_backprop_trainer_unit.sv */
// Top level of the 3-3-3 sigmoid perceptron trainer: command sequencer,
// node lanes and merge stage. Uses mbt_pkg, mbt_lane, mbt_merge.
//
// channel | dir | tdata                                   | tuser
// in_     | in  | 120b: weight_index..target_c            | command
// out_    | out | 56b: class_index, score, error_sum, cnt | -
//
// When samples are held, apply runs one 40-step serial divide per weight,
// lanes in parallel; else it skips the divides. In the forward pass the
// sequencer walks one source node per cycle across all lanes.
// rst_n clears weights, gradient sums and the sample count.
// A finished result waits in the output register; the next transfer is
// taken while it waits, and the sequencer holds only at its own finish.
module mlp_backprop_trainer_unit import mbt_pkg::*; #(
  parameter int WEIGHT_BITS       = 16,
  parameter int SAMPLE_COUNT_BITS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  // weight_index, weight_value, feature_a/b/c, target_a/b/c, zero pad
  input  logic [119:0]  in_tdata,
  // command
  input  logic [1:0]    in_tuser,
  output logic          out_tvalid,
  input  logic          out_tready,
  // class_index, score, error_sum, samples_held, zero pad
  output logic [55:0]   out_tdata
);

  localparam int SCB = SAMPLE_COUNT_BITS;
  localparam int PW  = WEIGHT_BITS + 17;
  localparam int SW  = PW + 2;

  state_t                state_r, state_nxt;
  item_t                 item_r;
  logic [KW-1:0]         k_r, k_nxt;
  logic                  layer_r, layer_nxt;
  logic [DIV_CW-1:0]     div_r, div_nxt;
  logic [SCB-1:0]        count_r, count_nxt;
  logic                  out_valid_r, ld;
  logic [1:0]            cls_r, cls_nxt;
  logic [ACT_BITS-1:0]   score_r, score_nxt;
  logic signed [17:0]    err_r, err_nxt;
  logic [15:0]           held_r;
  ctl_t                  ctl;

  logic [ACT_BITS-1:0]   a1_w [NODES];
  logic [ACT_BITS-1:0]   a2_w [NODES];
  logic signed [16:0]    d2_w [NODES];
  logic signed [PW-1:0]  p_w  [NODES];
  logic [1:0]            m_cls;
  logic [ACT_BITS-1:0]   m_score;
  logic signed [17:0]    m_err;
  logic signed [SW-1:0]  m_sum;

  logic [LW-1:0]         ki;
  logic                  wr_ok, wr_layer;
  logic [KW-1:0]         wr_src;
  logic [LW-1:0]         wr_lane;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, held_r, err_r, score_r, cls_r};

  for (genvar j = 0; j < NODES; j++) begin : g_lane
    mbt_lane #(
      .LANE(j), .WEIGHT_BITS(WEIGHT_BITS), .SAMPLE_COUNT_BITS(SAMPLE_COUNT_BITS)
    ) u_lane (
      .clk(clk), .rst_n(rst_n), .ctl(ctl),
      .target($signed(item_r.targ[j])), .sum(m_sum), .cnt(count_r),
      .a1(a1_w[j]), .a2(a2_w[j]), .d2(d2_w[j]), .p(p_w[j])
    );
  end

  mbt_merge #(.WEIGHT_BITS(WEIGHT_BITS)) u_merge (
    .clk(clk), .a2(a2_w), .d2(d2_w), .p(p_w),
    .cls(m_cls), .score(m_score), .err(m_err), .sum(m_sum)
  );

  always_comb begin
    wr_ok    = 1'b0;
    wr_layer = 1'b0;
    wr_src   = '0;
    wr_lane  = '0;
    for (int l = 0; l < 2; l++) begin
      for (int s = 0; s <= NODES; s++) begin
        for (int d = 0; d < NODES; d++) begin
          if (item_r.idx == 5'(l * LAYER_W + s * NODES + d)) begin
            wr_ok    = 1'b1;
            wr_layer = 1'(l);
            wr_src   = KW'(s);
            wr_lane  = LW'(d);
          end
        end
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    layer_nxt = layer_r;
    div_nxt   = div_r;
    count_nxt = count_r;
    ld        = 1'b0;
    cls_nxt   = '0;
    score_nxt = '0;
    err_nxt   = '0;
    ki        = LW'(k_r - KW'(1));
    ctl.op    = L_NOP;
    ctl.layer = layer_r;
    ctl.k     = k_r;
    ctl.lane  = wr_lane;
    ctl.act0  = (k_r == '0) ? 16'sd4096 : $signed(item_r.feat[ki]);
    ctl.act1  = (k_r == '0) ? 16'sd4096 : $signed({3'b0, a1_w[ki]});
    ctl.wdata = $signed(item_r.wval);

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          k_nxt     = '0;
          layer_nxt = 1'b0;
          unique case (cmd_t'(in_tuser))
            CMD_WRITE:    state_nxt = ST_WRITE;
            CMD_APPLY:    state_nxt = (count_r == '0) ? ST_GCLR : ST_DLOAD;
            default:      state_nxt = ST_FWD;
          endcase
        end
      end
      ST_WRITE: begin
        ctl.layer = wr_layer;
        ctl.k     = wr_src;
        if (wr_ok) ctl.op = L_WRITE;
        state_nxt = ST_FINISH;
      end
      ST_FWD: begin
        ctl.op = L_MAC;
        if (k_r == KW'(NODES)) begin
          k_nxt     = '0;
          state_nxt = ST_SIG;
        end else begin
          k_nxt = k_r + KW'(1);
        end
      end
      ST_SIG: begin
        ctl.op = L_SIG;
        if (!layer_r) begin
          layer_nxt = 1'b1;
          state_nxt = ST_FWD;
        end else begin
          state_nxt = ST_MERGE;
        end
      end
      ST_MERGE: begin
        if (item_r.cmd == CMD_CLASSIFY) begin
          state_nxt = ST_FINISH;
        end else begin
          k_nxt     = KW'(1);
          state_nxt = ST_BKMUL;
        end
      end
      ST_BKMUL: begin
        ctl.op    = L_BKMUL;
        state_nxt = ST_BKSUM;
      end
      ST_BKSUM: state_nxt = ST_BKD1;
      ST_BKD1: begin
        ctl.op = L_D1;
        if (k_r == KW'(NODES)) begin
          k_nxt     = '0;
          state_nxt = ST_GMUL;
        end else begin
          k_nxt     = k_r + KW'(1);
          state_nxt = ST_BKMUL;
        end
      end
      ST_GMUL: begin
        ctl.op    = L_GMUL;
        state_nxt = ST_GADD;
      end
      ST_GADD: begin
        ctl.op = L_GADD;
        if (k_r == KW'(NODES)) begin
          if (count_r != '1) count_nxt = count_r + SCB'(1);
          state_nxt = ST_FINISH;
        end else begin
          k_nxt     = k_r + KW'(1);
          state_nxt = ST_GMUL;
        end
      end
      ST_GCLR: begin
        ctl.op    = L_GCLR;
        count_nxt = '0;
        state_nxt = ST_FINISH;
      end
      ST_DLOAD: begin
        ctl.op    = L_DLOAD;
        div_nxt   = '0;
        state_nxt = ST_DSTEP;
      end
      ST_DSTEP: begin
        ctl.op = L_DSTEP;
        if (div_r == DIV_CW'(GRAD_BITS - 1)) state_nxt = ST_DEND;
        else div_nxt = div_r + DIV_CW'(1);
      end
      ST_DEND: begin
        ctl.op    = L_DEND;
        state_nxt = ST_DLOAD;
        if (k_r == KW'(NODES)) begin
          k_nxt = '0;
          if (layer_r) begin
            count_nxt = '0;
            state_nxt = ST_FINISH;
          end else begin
            layer_nxt = 1'b1;
          end
        end else begin
          k_nxt = k_r + KW'(1);
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || out_tready) begin
          ld        = 1'b1;
          state_nxt = ST_IDLE;
        end
        if (item_r.cmd == CMD_CLASSIFY) begin
          cls_nxt   = m_cls;
          score_nxt = m_score;
        end
        if (item_r.cmd == CMD_TRAIN) err_nxt = m_err;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      k_r         <= '0;
      layer_r     <= 1'b0;
      div_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      layer_r <= layer_nxt;
      div_r   <= div_nxt;
      count_r <= count_nxt;
      if (ld) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.cmd  <= cmd_t'(in_tuser);
      item_r.idx  <= in_tdata[4:0];
      item_r.wval <= in_tdata[20:5];
      for (int j = 0; j < NODES; j++) begin
        item_r.feat[j] <= in_tdata[21 + 16*j +: 16];
        item_r.targ[j] <= in_tdata[69 + 16*j +: 16];
      end
    end
    if (ld) begin
      cls_r   <= cls_nxt;
      score_r <= score_nxt;
      err_r   <= err_nxt;
      held_r  <= 16'(count_r);
    end
  end

endmodule

/* hw/rtl/mbt_lane.sv */
// One node lane: owns the weights and gradient sums feeding its node,
// does MAC, sigmoid lookup, deltas, gradient updates and a serial divider. Uses mbt_pkg.
module mbt_lane import mbt_pkg::*; #(
  parameter int LANE              = 0,
  parameter int WEIGHT_BITS       = 16,
  parameter int SAMPLE_COUNT_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  ctl_t                                 ctl,
  input  logic signed [FEAT_BITS-1:0]          target,
  input  logic signed [WEIGHT_BITS+18:0]       sum,
  input  logic [SAMPLE_COUNT_BITS-1:0]         cnt,
  output logic [ACT_BITS-1:0]                  a1,
  output logic [ACT_BITS-1:0]                  a2,
  output logic signed [16:0]                   d2,
  output logic signed [WEIGHT_BITS+16:0]       p
);

  localparam int WB    = WEIGHT_BITS;
  localparam int SCB   = SAMPLE_COUNT_BITS;
  localparam int ACC_W = WB + 18;
  localparam int PW    = WB + 17;
  localparam int SW    = PW + 2;
  localparam int D1W   = SW - 12;
  localparam int GPW   = WB + 11;
  localparam int AW    = 48;
  localparam logic signed [41:0] W_MAX = (42'sd1 <<< (WB - 1)) - 42'sd1;
  localparam logic signed [41:0] W_MIN = -(42'sd1 <<< (WB - 1));
  localparam logic signed [AW-1:0] G_MAX = (48'sd1 <<< (GRAD_BITS - 1)) - 48'sd1;
  localparam logic signed [AW-1:0] G_MIN = -(48'sd1 <<< (GRAD_BITS - 1));
  localparam logic signed [ACC_W-1:0] Z_MAX = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] Z_MIN = ACC_W'(-32768);

  logic signed [WB-1:0]        w_r [2][NODES+1];
  logic signed [GRAD_BITS-1:0] g_r [2][NODES+1];
  logic signed [ACC_W-1:0]     acc_r;
  logic [ACT_BITS-1:0]         a1_r, a2_r;
  logic [10:0]                 da_r;
  logic signed [16:0]          d2_r;
  logic signed [D1W-1:0]       d1_r;
  logic signed [PW-1:0]        p_r;
  logic signed [GPW-1:0]       gp0_r;
  logic signed [20:0]          gp1_r;
  logic [GRAD_BITS-1:0]        num_r, quo_r;
  logic [SCB-1:0]              rem_r;
  logic                        neg_r;

  logic signed [FEAT_BITS-1:0]    act;
  logic signed [WB-1:0]           w_sel, w_bk;
  logic signed [GRAD_BITS-1:0]    g_sel, g0, g1;
  logic signed [ACC_W-1:0]        prod, acc_nxt, z;
  logic signed [FEAT_BITS-1:0]    z16;
  logic [FEAT_BITS-1:0]           off;
  logic [SIG_AW-1:0]              rom_a;
  logic [ACT_BITS-1:0]            sig_v;
  logic [25:0]                    da_full;
  logic [ACT_BITS-1:0]            one_m;
  logic signed [SW-13:0]          s_f;
  logic signed [SW-1:0]           t_d1;
  logic signed [WB+22:0]          gp0_full;
  logic signed [32:0]             gp1_full;
  logic signed [AW-1:0]           gs0, gs1;
  logic signed [GRAD_BITS-1:0]    gs0_c, gs1_c;
  logic [SCB:0]                   trial;
  logic                           ge;
  logic signed [41:0]             qv, diff, wr_ext;
  logic signed [WB-1:0]           w_upd, w_wr;

  assign a1 = a1_r;
  assign a2 = a2_r;
  assign d2 = d2_r;
  assign p  = p_r;

  always_comb begin
    act     = ctl.layer ? ctl.act1 : ctl.act0;
    w_sel   = w_r[ctl.layer][ctl.k];
    w_bk    = w_r[1][ctl.k];
    g_sel   = g_r[ctl.layer][ctl.k];
    g0      = g_r[0][ctl.k];
    g1      = g_r[1][ctl.k];
    prod    = ACC_W'(act * w_sel);
    acc_nxt = ((ctl.k == '0) ? '0 : acc_r) + prod;

    z = acc_r >>> 12;
    if (z > Z_MAX) z16 = 16'sh7FFF;
    else if (z < Z_MIN) z16 = -16'sh8000;
    else z16 = FEAT_BITS'(z);
    off   = {~z16[15], z16[14:0]};
    rom_a = SIG_AW'((32'(off) * SIG_DEPTH) >> 16);
    sig_v = SIG_ROM[rom_a];

    one_m   = ACT_BITS'(ONE_Q12) - a1_r;
    da_full = 26'(a1_r) * 26'(one_m);

    s_f  = (SW-12)'(sum >>> 12);
    t_d1 = SW'(s_f * $signed({1'b0, da_r}));

    gp0_full = ctl.act0 * d1_r;
    gp1_full = ctl.act1 * d2_r;

    gs0 = AW'(g0) + AW'(gp0_r);
    gs1 = AW'(g1) + AW'(gp1_r);
    if (gs0 > G_MAX) gs0_c = GRAD_BITS'(G_MAX);
    else if (gs0 < G_MIN) gs0_c = GRAD_BITS'(G_MIN);
    else gs0_c = GRAD_BITS'(gs0);
    if (gs1 > G_MAX) gs1_c = GRAD_BITS'(G_MAX);
    else if (gs1 < G_MIN) gs1_c = GRAD_BITS'(G_MIN);
    else gs1_c = GRAD_BITS'(gs1);

    trial = {rem_r, num_r[GRAD_BITS-1]};
    ge    = (trial >= (SCB+1)'(cnt));

    qv   = neg_r ? -$signed(42'(quo_r)) : $signed(42'(quo_r));
    diff = 42'(w_sel) - qv;
    if (diff > W_MAX) w_upd = WB'(W_MAX);
    else if (diff < W_MIN) w_upd = WB'(W_MIN);
    else w_upd = WB'(diff);

    wr_ext = 42'(ctl.wdata);
    if (wr_ext > W_MAX) w_wr = WB'(W_MAX);
    else if (wr_ext < W_MIN) w_wr = WB'(W_MIN);
    else w_wr = WB'(wr_ext);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int l = 0; l < 2; l++) begin
        for (int s = 0; s <= NODES; s++) begin
          w_r[l][s] <= '0;
          g_r[l][s] <= '0;
        end
      end
    end else begin
      case (ctl.op)
        L_WRITE: if (ctl.lane == LW'(LANE)) w_r[ctl.layer][ctl.k] <= w_wr;
        L_GADD: begin
          g_r[0][ctl.k] <= gs0_c;
          g_r[1][ctl.k] <= gs1_c;
        end
        L_GCLR: begin
          for (int l = 0; l < 2; l++) begin
            for (int s = 0; s <= NODES; s++) g_r[l][s] <= '0;
          end
        end
        L_DEND: begin
          w_r[ctl.layer][ctl.k] <= w_upd;
          g_r[ctl.layer][ctl.k] <= '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.op)
      L_MAC: begin
        acc_r <= acc_nxt;
        if (ctl.layer) da_r <= 11'(da_full >> 12);
      end
      L_SIG: begin
        if (!ctl.layer) begin
          a1_r <= sig_v;
        end else begin
          a2_r <= sig_v;
          d2_r <= $signed({4'b0, sig_v}) - 17'(target);
        end
      end
      L_BKMUL: p_r <= PW'(w_bk * d2_r);
      L_D1: if (ctl.k == KW'(LANE + 1)) d1_r <= D1W'(t_d1 >>> 12);
      L_GMUL: begin
        gp0_r <= GPW'(gp0_full >>> 12);
        gp1_r <= 21'(gp1_full >>> 12);
      end
      L_DLOAD: begin
        neg_r <= g_sel[GRAD_BITS-1];
        num_r <= g_sel[GRAD_BITS-1] ? GRAD_BITS'(-g_sel) : GRAD_BITS'(g_sel);
        rem_r <= '0;
        quo_r <= '0;
      end
      L_DSTEP: begin
        num_r <= num_r << 1;
        quo_r <= {quo_r[GRAD_BITS-2:0], ge};
        rem_r <= ge ? SCB'(trial - (SCB+1)'(cnt)) : SCB'(trial);
      end
      default: ;
    endcase
  end

endmodule

/* hw/rtl/mbt_merge.sv */
// Merge stage across lanes: argmax of output activations, error sum,
// and the backprop dot-product sum. Uses mbt_pkg.
module mbt_merge import mbt_pkg::*; #(
  parameter int WEIGHT_BITS = 16
) (
  input  logic                              clk,
  input  logic [ACT_BITS-1:0]               a2 [NODES],
  input  logic signed [16:0]                d2 [NODES],
  input  logic signed [WEIGHT_BITS+16:0]    p  [NODES],
  output logic [1:0]                        cls,
  output logic [ACT_BITS-1:0]               score,
  output logic signed [17:0]                err,
  output logic signed [WEIGHT_BITS+18:0]    sum
);

  localparam int SW = WEIGHT_BITS + 19;

  logic [1:0]                cls_r, best;
  logic [ACT_BITS-1:0]       score_r, best_v;
  logic signed [17:0]        err_r, err_c;
  logic signed [SW-1:0]      sum_r, sum_v;
  logic signed [18:0]        err_v;

  assign cls   = cls_r;
  assign score = score_r;
  assign err   = err_r;
  assign sum   = sum_r;

  always_comb begin
    best   = '0;
    best_v = a2[0];
    err_v  = '0;
    sum_v  = '0;
    for (int j = 0; j < NODES; j++) begin
      if (a2[j] > best_v) begin
        best   = 2'(j);
        best_v = a2[j];
      end
      err_v = err_v + 19'(d2[j]);
      sum_v = sum_v + SW'(p[j]);
    end
    if (err_v > 19'sd131071) err_c = 18'sh1FFFF;
    else if (err_v < -19'sd131072) err_c = -18'sh20000;
    else err_c = 18'(err_v);
  end

  always_ff @(posedge clk) begin
    cls_r   <= best + 2'd1;
    score_r <= best_v;
    err_r   <= err_c;
    sum_r   <= sum_v;
  end

endmodule
